### src/ipv4p_pkg.sv
package ipv4p_pkg;

   // Parser phase codes
   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_ZERO  = 2'd1;
   localparam logic [1:0] PH_NUM   = 2'd2;
   localparam logic [1:0] PH_DRAIN = 2'd3;

   // Number base codes; the spare code acts as decimal
   localparam logic [1:0] BASE_DEC = 2'd0;
   localparam logic [1:0] BASE_OCT = 2'd1;
   localparam logic [1:0] BASE_HEX = 2'd2;

   localparam logic [31:0] TAIL24_MAX = 32'h00ff_ffff;
   localparam logic [31:0] TAIL16_MAX = 32'h0000_ffff;
   localparam logic [31:0] TAIL8_MAX  = 32'h0000_00ff;

   typedef struct packed {
      logic       is_dec;
      logic       is_hex_letter;
      logic       is_dot;
      logic       is_x;
      logic       is_nul;
      logic       is_ws;
      logic [3:0] digit;
   } char_class_type;

   typedef struct packed {
      logic        fire;
      logic [31:0] address_value;
      logic        parse_ok;
   } parse_result_type;

endpackage

### src/ipv4p_char_class.sv
module ipv4p_char_class (
   input  logic [7:0]               char_byte,
   output ipv4p_pkg::char_class_type cls
);
   import ipv4p_pkg::*;

   logic lower_af;
   logic upper_af;

   assign lower_af = (char_byte >= 8'h61) && (char_byte <= 8'h66);
   assign upper_af = (char_byte >= 8'h41) && (char_byte <= 8'h46);

   always_comb begin
      cls.is_dec        = (char_byte >= 8'h30) && (char_byte <= 8'h39);
      cls.is_hex_letter = lower_af || upper_af;
      cls.is_dot        = (char_byte == 8'h2e);
      cls.is_x          = (char_byte == 8'h78) || (char_byte == 8'h58);
      cls.is_nul        = (char_byte == 8'h00);
      // space, or tab through carriage return
      cls.is_ws         = (char_byte == 8'h20) ||
                          ((char_byte >= 8'h09) && (char_byte <= 8'h0d));
      // letters a-f / A-F have low nibble 1..6, value 10..15
      cls.digit         = cls.is_dec ? char_byte[3:0] : (char_byte[3:0] + 4'd9);
   end

endmodule

### src/ipv4p_parse_core.sv
module ipv4p_parse_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_en,
   input  ipv4p_pkg::char_class_type   cls,
   output ipv4p_pkg::parse_result_type res
);
   import ipv4p_pkg::*;

   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  base_ff, base_in;
   logic [31:0] value_ff, value_in;
   logic [31:0] part_ff [3];
   logic [31:0] part_in [3];
   logic [1:0]  count_ff, count_in;

   logic        num_mode;
   logic [1:0]  eff_base;
   logic        end_req;
   logic        candidate;
   logic [31:0] scaled;
   logic        ok;
   logic [31:0] packed_value;

   // running value times the radix, as shifts and, for decimal, one add
   always_comb begin
      unique case (eff_base)
         BASE_OCT: scaled = {value_ff[28:0], 3'b000};
         BASE_HEX: scaled = {value_ff[27:0], 4'b0000};
         default:  scaled = {value_ff[28:0], 3'b000} + {value_ff[30:0], 1'b0};
      endcase
   end

   // fit check and packing of the stored parts over the tail
   always_comb begin
      ok           = candidate && (cls.is_nul || cls.is_ws);
      packed_value = value_ff;
      unique case (count_ff)
         2'd0: ;
         2'd1: begin
            if (value_ff > TAIL24_MAX) ok = 1'b0;
            packed_value = value_ff | {part_ff[0][7:0], 24'd0};
         end
         2'd2: begin
            if (value_ff > TAIL16_MAX) ok = 1'b0;
            packed_value = value_ff | {part_ff[0][7:0], 24'd0} | {part_ff[1][15:0], 16'd0};
         end
         default: begin
            if (value_ff > TAIL8_MAX) ok = 1'b0;
            packed_value = value_ff | {part_ff[0][7:0], 24'd0} |
                           {part_ff[1][15:0], 16'd0} | {part_ff[2][23:0], 8'd0};
         end
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      base_in    = base_ff;
      value_in   = value_ff;
      part_in    = part_ff;
      count_in   = count_ff;
      num_mode   = 1'b0;
      eff_base   = base_ff;
      end_req    = 1'b0;
      candidate  = 1'b0;

      unique case (phase_ff)
         PH_DRAIN: begin
            if (cls.is_nul) phase_in = PH_START;
         end
         PH_ZERO: begin
            phase_in = PH_NUM;
            if (cls.is_x) begin
               base_in = BASE_HEX;
            end else begin
               base_in  = BASE_OCT;
               eff_base = BASE_OCT;
               num_mode = 1'b1;
            end
         end
         PH_NUM: begin
            num_mode = 1'b1;
         end
         default: begin
            if (!cls.is_dec) begin
               end_req = 1'b1;
            end else begin
               base_in  = BASE_DEC;
               value_in = {28'd0, cls.digit};
               phase_in = (cls.digit == 4'd0) ? PH_ZERO : PH_NUM;
            end
         end
      endcase

      if (num_mode) begin
         priority if (cls.is_dec) begin
            value_in = scaled + {28'd0, cls.digit};
         end else if (eff_base == BASE_HEX && cls.is_hex_letter) begin
            value_in = {value_ff[27:0], cls.digit};
         end else if (cls.is_dot) begin
            if (count_ff == 2'd3) begin
               end_req = 1'b1;
            end else begin
               part_in[count_ff] = value_ff;
               count_in          = count_ff + 2'd1;
               value_in          = 32'd0;
               base_in           = BASE_DEC;
               phase_in          = PH_START;
            end
         end else begin
            end_req   = 1'b1;
            candidate = 1'b1;
         end
      end

      // end of parse: clear everything, drain unless the string ended
      if (end_req) begin
         base_in  = BASE_DEC;
         value_in = 32'd0;
         part_in  = '{32'd0, 32'd0, 32'd0};
         count_in = 2'd0;
         phase_in = cls.is_nul ? PH_START : PH_DRAIN;
      end

      res.fire          = end_req;
      res.parse_ok      = ok;
      res.address_value = ok ? packed_value : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         base_ff  <= BASE_DEC;
         value_ff <= 32'd0;
         part_ff  <= '{32'd0, 32'd0, 32'd0};
         count_ff <= 2'd0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         base_ff  <= base_in;
         value_ff <= value_in;
         part_ff  <= part_in;
         count_ff <= count_in;
      end
   end

endmodule

### src/ipv4_text_address_parser_top.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_stall  | req_char_byte[7:0]
// rsp     | out       | rsp_valid/rsp_stall  | rsp_address_value[31:0], rsp_parse_ok
//
// One character per cycle while req_stall is low: a character is captured in
// the input register, then classified and applied to the parser state, and a
// finished address lands in the result register at the same edge.
// Synchronous reset returns the parser to the start of a number.
// A full result register with rsp_stall high stalls input only when the
// pending character would end a parse; other characters keep flowing.
module ipv4_text_address_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_address_value,
   output logic        rsp_parse_ok
);
   import ipv4p_pkg::*;

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             out_valid_ff, out_valid_in;
   logic [31:0]      out_value_ff;
   logic             out_ok_ff;
   char_class_type   cls;
   parse_result_type res;
   logic             advance;

   ipv4p_char_class u_class (
      .char_byte (in_byte_ff),
      .cls       (cls)
   );

   ipv4p_parse_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .cls     (cls),
      .res     (res)
   );

   // Advance the held character unless it ends a parse and the result slot is busy
   assign advance   = in_valid_ff && (!res.fire || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Input register: load a new transaction whenever the held one moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_char_byte;
      end
   end

   // Result register: fill on a finished parse, drop once taken
   always_comb begin
      if (advance && res.fire) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res.fire) begin
         out_value_ff <= res.address_value;
         out_ok_ff    <= res.parse_ok;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_address_value = out_value_ff;
   assign rsp_parse_ok      = out_ok_ff;

endmodule
